>>> rtl/field_vector_dec_dip_rotate_defines.svh
// ----------------------------------------------------------------------------
// field vector rotation assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef FIELD_VECTOR_DEC_DIP_ROTATE_DEFINES_SVH
`define FIELD_VECTOR_DEC_DIP_ROTATE_DEFINES_SVH

// same-cycle implication on the block clock
`define FVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("fvd: same-cycle property failed");

// next-cycle implication on the block clock
`define FVD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("fvd: next-cycle property failed");

`endif

>>> rtl/fvd_pkg.sv
// ----------------------------------------------------------------------------
// fvd_pkg
// types, constants and helper functions of the field vector rotation block
// ----------------------------------------------------------------------------
package fvd_pkg;

    // raw sample width of every input component
    localparam int SAMPLE_WIDTH    = 16;
    localparam int FVD_QUEUE_DEPTH = 4;

    // Q1.14 one
    localparam logic signed [15:0] QONE = 16'sd16384;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_DEC_COS = 3'd1;
    localparam logic [2:0] CFG_DEC_SIN = 3'd2;
    localparam logic [2:0] CFG_DIP_COS = 3'd3;
    localparam logic [2:0] CFG_DIP_SIN = 3'd4;

    // mode codes
    localparam logic [1:0] MODE_BOTH    = 2'd0;
    localparam logic [1:0] MODE_DEC     = 2'd1;
    localparam logic [1:0] MODE_DIP     = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] mag_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_z;
        logic signed [SAMPLE_WIDTH-1:0] grav_x;
        logic signed [SAMPLE_WIDTH-1:0] grav_y;
        logic signed [SAMPLE_WIDTH-1:0] grav_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               degenerate;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] dec_cos;
        logic signed [15:0] dec_sin;
        logic signed [15:0] dip_cos;
        logic signed [15:0] dip_sin;
    } t_cfg;

    // one multiply-accumulate step of the cross and dot products
    typedef struct packed {
        logic [1:0] ki;
        logic [1:0] vi;
        logic       neg;
        logic       first;
        logic       wr;
        logic [1:0] tgt;
    } t_cr_op;

    localparam logic [1:0] TGT_DOT = 2'd3;

    // step table for k x v and k . v
    function automatic t_cr_op fvd_cr_step(input logic [3:0] st);
        t_cr_op op;
        op = '0;
        unique case (st)
            4'd0: op = '{ki: 2'd1, vi: 2'd2, neg: 1'b0, first: 1'b1, wr: 1'b0, tgt: 2'd0};
            4'd1: op = '{ki: 2'd2, vi: 2'd1, neg: 1'b1, first: 1'b0, wr: 1'b1, tgt: 2'd0};
            4'd2: op = '{ki: 2'd2, vi: 2'd0, neg: 1'b0, first: 1'b1, wr: 1'b0, tgt: 2'd1};
            4'd3: op = '{ki: 2'd0, vi: 2'd2, neg: 1'b1, first: 1'b0, wr: 1'b1, tgt: 2'd1};
            4'd4: op = '{ki: 2'd0, vi: 2'd1, neg: 1'b0, first: 1'b1, wr: 1'b0, tgt: 2'd2};
            4'd5: op = '{ki: 2'd1, vi: 2'd0, neg: 1'b1, first: 1'b0, wr: 1'b1, tgt: 2'd2};
            4'd6: op = '{ki: 2'd0, vi: 2'd0, neg: 1'b0, first: 1'b1, wr: 1'b0, tgt: TGT_DOT};
            4'd7: op = '{ki: 2'd1, vi: 2'd1, neg: 1'b0, first: 1'b0, wr: 1'b0, tgt: TGT_DOT};
            4'd8: op = '{ki: 2'd2, vi: 2'd2, neg: 1'b0, first: 1'b0, wr: 1'b1, tgt: TGT_DOT};
            default: op = '0;
        endcase
        return op;
    endfunction

    // Q.56 sum to Q1.14, half away from zero, limited to one
    function automatic logic signed [15:0] fvd_round_q56(input logic signed [65:0] acc);
        logic [65:0] mag;
        logic [23:0] m;
        mag = acc[65] ? 66'(-acc) : 66'(acc);
        mag = mag + (66'd1 << 41);
        m   = mag[65:42];
        if (m > 24'd16384) begin
            m = 24'd16384;
        end
        return acc[65] ? -16'(m) : 16'(m);
    endfunction

endpackage

>>> rtl/fvd_front.sv
// ----------------------------------------------------------------------------
// fvd_front
// accepts items and holds them in a short queue ahead of the rotation engine
// ----------------------------------------------------------------------------
module fvd_front import fvd_pkg::*; #(
    parameter int QUEUE_DEPTH = FVD_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_head_valid,
    output t_in_item o_head,
    input  logic     i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_in_item         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/fvd_back.sv
// ----------------------------------------------------------------------------
// fvd_back
// normalizes, rotates and delivers one item at a time with a shared
// multiply-accumulate, a bit-serial square root and a bit-serial divider
// ----------------------------------------------------------------------------
module fvd_back import fvd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_head_valid,
    input  t_in_item  i_head,
    output logic      o_pop,
    output logic      o_done,
    output t_out_item o_result
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SQ   = 11'b00000000010,
        S_SQZ  = 11'b00000000100,
        S_SQRT = 11'b00000001000,
        S_DIVI = 11'b00000010000,
        S_DIV  = 11'b00000100000,
        S_DIVW = 11'b00001000000,
        S_CR   = 11'b00010000000,
        S_CRD  = 11'b00100000000,
        S_ROT  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    typedef enum logic [4:0] {
        J_MAG  = 5'b00001,
        J_GRAV = 5'b00010,
        J_AXIS = 5'b00100,
        J_DEC  = 5'b01000,
        J_DIP  = 5'b10000
    } t_job;

    t_state              r_state;
    t_job                r_job;
    logic                r_ok;
    logic                r_done;
    t_out_item           r_res;
    t_in_item            r_item;
    logic signed [31:0]  r_a   [3];
    logic signed [15:0]  r_v   [3];
    logic signed [15:0]  r_k   [3];
    logic signed [31:0]  r_cr  [3];
    logic signed [31:0]  r_dot;
    logic signed [47:0]  r_t;
    logic signed [65:0]  r_acc;
    logic [63:0]         r_rem;
    logic [63:0]         r_root;
    logic [33:0]         r_drem;
    logic [15:0]         r_dq;
    logic [1:0]          r_ci;
    logic [1:0]          r_pi;
    logic [3:0]          r_step;
    logic [4:0]          r_bi;

    logic signed [65:0]  n_acc;
    logic signed [47:0]  w_ma;
    logic signed [17:0]  w_mb;
    logic [5:0]          w_sh;
    logic signed [65:0]  w_p;
    logic signed [65:0]  w_ps;
    logic [31:0]         w_abs;
    t_cr_op              w_op;
    logic signed [15:0]  w_c;
    logic signed [15:0]  w_s;
    logic signed [17:0]  w_qc;
    logic [63:0]         w_bit;
    logic [63:0]         w_trial;
    logic [46:0]         w_num;
    logic [33:0]         w_dtry;
    logic                w_dge;
    logic [15:0]         w_q;
    logic signed [15:0]  w_norm;

    assign o_pop    = (r_state == S_IDLE) && i_head_valid;
    assign o_done   = r_done;
    assign o_result = r_res;

    // operand helpers
    assign w_abs  = r_a[r_ci][31] ? 32'(-r_a[r_ci]) : 32'(r_a[r_ci]);
    assign w_op   = fvd_cr_step(r_step);
    assign w_c    = (r_job == J_DEC) ? i_cfg.dec_cos : i_cfg.dip_cos;
    assign w_s    = (r_job == J_DEC) ? i_cfg.dec_sin : i_cfg.dip_sin;
    assign w_qc   = 18'(QONE) - 18'(w_c);

    // square root trial
    assign w_bit   = 64'd1 << {r_bi, 1'b0};
    assign w_trial = r_root + w_bit;

    // divider: numerator, trial subtract, clamped signed quotient
    assign w_num  = {1'b0, w_abs, 14'd0} + 47'(r_root[32:1]);
    assign w_dtry = {r_drem[32:0], r_dq[15]};
    assign w_dge  = (w_dtry >= {1'b0, r_root[32:0]});
    assign w_q    = (r_dq > 16'd16384) ? 16'd16384 : r_dq;
    assign w_norm = r_a[r_ci][31] ? -16'(w_q) : 16'(w_q);

    // shared multiply-accumulate
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_sh  = '0;
        n_acc = r_acc;
        unique case (r_state)
            S_SQ: begin
                unique case (r_pi)
                    2'd0: begin
                        w_ma = 48'(w_abs[15:0]);
                        w_mb = 18'(w_abs[15:0]);
                        w_sh = 6'd0;
                    end
                    2'd1: begin
                        w_ma = 48'(w_abs[31:16]);
                        w_mb = 18'(w_abs[15:0]);
                        w_sh = 6'd17;
                    end
                    default: begin
                        w_ma = 48'(w_abs[31:16]);
                        w_mb = 18'(w_abs[31:16]);
                        w_sh = 6'd32;
                    end
                endcase
            end
            S_CR: begin
                w_ma = 48'(r_k[w_op.ki]);
                w_mb = 18'(r_v[w_op.vi]);
            end
            S_ROT: begin
                unique case (r_step)
                    4'd0: begin
                        w_ma = 48'(w_c);
                        w_mb = 18'(r_v[r_ci]);
                        w_sh = 6'd28;
                    end
                    4'd1: begin
                        w_ma = 48'(r_cr[r_ci]);
                        w_mb = 18'(w_s);
                        w_sh = 6'd14;
                    end
                    4'd2: begin
                        w_ma = 48'(r_dot);
                        w_mb = 18'(r_k[r_ci]);
                    end
                    4'd3: begin
                        w_ma = r_t;
                        w_mb = w_qc;
                    end
                    default: begin
                        w_ma = '0;
                    end
                endcase
            end
            default: begin
                w_ma = '0;
            end
        endcase
        w_p  = w_ma * w_mb;
        w_ps = w_p <<< w_sh;
        unique case (r_state)
            S_SQ: n_acc = r_acc + w_ps;
            S_CR: n_acc = (w_op.first ? 66'sd0 : r_acc) + (w_op.neg ? -w_p : w_p);
            S_ROT: begin
                unique case (r_step)
                    4'd0:    n_acc = w_ps;
                    4'd1:    n_acc = r_acc - w_ps;
                    4'd3:    n_acc = r_acc + w_ps;
                    default: n_acc = r_acc;
                endcase
            end
            default: n_acc = r_acc;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= J_MAG;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                // take the next queued item
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_item  <= i_head;
                        r_a[0]  <= 32'(i_head.mag_x);
                        r_a[1]  <= 32'(i_head.mag_y);
                        r_a[2]  <= 32'(i_head.mag_z);
                        r_acc   <= '0;
                        r_ci    <= '0;
                        r_pi    <= '0;
                        r_ok    <= 1'b1;
                        r_job   <= J_MAG;
                        r_state <= S_SQ;
                    end
                end
                // sum of squares, three partial products per component
                S_SQ: begin
                    r_acc <= n_acc;
                    if (r_pi == 2'd2) begin
                        r_pi <= '0;
                        if (r_ci == 2'd2) begin
                            r_state <= S_SQZ;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_pi <= r_pi + 1'b1;
                    end
                end
                // zero length check
                S_SQZ: begin
                    if (r_acc == '0) begin
                        r_ok    <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= r_acc[63:0];
                        r_root  <= '0;
                        r_bi    <= 5'd31;
                        r_state <= S_SQRT;
                    end
                end
                // integer square root, one result bit per cycle
                S_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + w_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_bi == '0) begin
                        r_ci    <= '0;
                        r_state <= S_DIVI;
                    end else begin
                        r_bi <= r_bi - 1'b1;
                    end
                end
                // load divider for one component
                S_DIVI: begin
                    r_drem  <= 34'(w_num[46:16]);
                    r_dq    <= w_num[15:0];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    r_drem <= w_dge ? (w_dtry - {1'b0, r_root[32:0]}) : w_dtry;
                    r_dq   <= {r_dq[14:0], w_dge};
                    if (r_step == 4'd15) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                // store normalized component, pick the next job
                S_DIVW: begin
                    if (r_job == J_MAG) begin
                        r_v[r_ci] <= w_norm;
                    end else begin
                        r_k[r_ci] <= w_norm;
                    end
                    if (r_ci == 2'd2) begin
                        priority case (r_job)
                            J_MAG: begin
                                r_a[0]  <= 32'(r_item.grav_x);
                                r_a[1]  <= 32'(r_item.grav_y);
                                r_a[2]  <= 32'(r_item.grav_z);
                                r_acc   <= '0;
                                r_ci    <= '0;
                                r_pi    <= '0;
                                r_job   <= J_GRAV;
                                r_state <= S_SQ;
                            end
                            J_GRAV: begin
                                r_step  <= '0;
                                r_job   <= (i_cfg.mode == MODE_DIP) ? J_AXIS : J_DEC;
                                r_state <= S_CR;
                            end
                            default: begin
                                r_step  <= '0;
                                r_job   <= J_DIP;
                                r_state <= S_CR;
                            end
                        endcase
                    end else begin
                        r_ci    <= r_ci + 1'b1;
                        r_state <= S_DIVI;
                    end
                end
                // cross and dot products of axis and field
                S_CR: begin
                    r_acc <= n_acc;
                    if (w_op.wr) begin
                        if (w_op.tgt == TGT_DOT) begin
                            r_dot <= n_acc[31:0];
                        end else begin
                            r_cr[w_op.tgt] <= n_acc[31:0];
                        end
                    end
                    if (r_step == 4'd8) begin
                        r_state <= S_CRD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                // dip axis is field x gravity, the negated k x v
                S_CRD: begin
                    if (r_job == J_AXIS) begin
                        r_a[0]  <= -r_cr[0];
                        r_a[1]  <= -r_cr[1];
                        r_a[2]  <= -r_cr[2];
                        r_acc   <= '0;
                        r_ci    <= '0;
                        r_pi    <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_ci    <= '0;
                        r_step  <= '0;
                        r_state <= S_ROT;
                    end
                end
                // rotation, five steps per component
                S_ROT: begin
                    r_acc <= n_acc;
                    if (r_step == 4'd2) begin
                        r_t <= w_p[47:0];
                    end
                    if (r_step == 4'd4) begin
                        r_v[r_ci] <= fvd_round_q56(r_acc);
                        r_step    <= '0;
                        if (r_ci == 2'd2) begin
                            if ((r_job == J_DEC) && (i_cfg.mode != MODE_DEC)) begin
                                r_job   <= J_AXIS;
                                r_state <= S_CR;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                // result register
                S_OUT: begin
                    r_done <= 1'b1;
                    if (r_ok) begin
                        r_res <= '{out_x: r_v[0], out_y: r_v[1], out_z: r_v[2],
                                   degenerate: 1'b0};
                    end else begin
                        r_res <= '{out_x: 16'sd0, out_y: 16'sd0, out_z: 16'sd0,
                                   degenerate: 1'b1};
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/field_vector_dec_dip_rotate.sv
// ----------------------------------------------------------------------------
// field_vector_dec_dip_rotate
// magnetometer field vector declination and dip compensation
// ----------------------------------------------------------------------------
// Usage:
//   An item (raw field and gravity vectors) is taken at a clock edge with
//   start high and busy low. Items wait in a queue of QUEUE_DEPTH entries;
//   busy is high only while that queue is full.
//   Each item yields one result, shown for a single cycle with o_done high.
//   The receiver cannot stall; results must be taken when shown.
//   The engine works on one item at a time, so a new item waits in the queue
//   until the last one is delivered. Its processing time is longer for dip
//   only than for declination only, longest for both rotations, and is set
//   by the bit-serial square root and the per-component divider run for each
//   normalized vector, and by the single shared multiply-accumulate.
//   Registers are to be written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no item is in flight; the block does not enforce this. Unknown indexes are ignored.
//   Synchronous active-low reset empties the queue, drops any item in
//   flight and restores the register defaults.
// ----------------------------------------------------------------------------
module field_vector_dec_dip_rotate import fvd_pkg::*; #(
    parameter int QUEUE_DEPTH = FVD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_done,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     w_push;
    logic     w_full;
    logic     w_head_valid;
    t_in_item w_head;
    logic     w_pop;

    assign busy   = w_full;
    assign w_push = start && !w_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_BOTH, dec_cos: QONE, dec_sin: 16'sd0,
                       dip_cos: QONE, dip_sin: 16'sd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:    r_cfg.mode    <= i_cfg_data[1:0];
                CFG_DEC_COS: r_cfg.dec_cos <= i_cfg_data;
                CFG_DEC_SIN: r_cfg.dec_sin <= i_cfg_data;
                CFG_DIP_COS: r_cfg.dip_cos <= i_cfg_data;
                CFG_DIP_SIN: r_cfg.dip_sin <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // item queue
    fvd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_item       (i_item),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // rotation engine
    fvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

>>> rtl/fvd_checker.sv
// ----------------------------------------------------------------------------
// fvd_checker
// port-level properties of the field vector rotation block
// ----------------------------------------------------------------------------
`include "field_vector_dec_dip_rotate_defines.svh"

module fvd_checker import fvd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);

    // results never come in consecutive cycles
    `FVD_ASSERT_NXT(a_done_gap, i_rst_n && o_done, !o_done)

    // a degenerate item carries a zero vector
    `FVD_ASSERT_IMP(a_degen_zero, o_done && o_result.degenerate, (o_result.out_x == 16'sd0) && (o_result.out_y == 16'sd0) && (o_result.out_z == 16'sd0))

    // every result component stays within one in Q1.14
    `FVD_ASSERT_IMP(a_unit_range, o_done, (o_result.out_x >= -16'sd16384) && (o_result.out_x <= 16'sd16384) && (o_result.out_y >= -16'sd16384) && (o_result.out_y <= 16'sd16384) && (o_result.out_z >= -16'sd16384) && (o_result.out_z <= 16'sd16384))

    // reset leaves the block quiet and ready
    `FVD_ASSERT_NXT(a_reset_quiet, !i_rst_n, !o_done && !busy)

endmodule

bind field_vector_dec_dip_rotate fvd_checker u_chk (.*);

>>> tb/tb_field_vector_dec_dip_rotate.sv
// ----------------------------------------------------------------------------
// tb_field_vector_dec_dip_rotate
// self-checking bench for the declination and dip field rotation block:
// a bit-exact fixed-point predictor fed from every accepted item, checked
// against every result strobe, over several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_field_vector_dec_dip_rotate;
    import fvd_pkg::*;

    localparam longint Q1        = 16384;
    localparam int     WDOG_MAX  = 20000;
    localparam int     DRAIN_CYC = 400;

    // scoreboard: rotation predictor and store of expected field vectors
    class rotation_scoreboard;
        logic [1:0]   mode;
        longint       dec_c, dec_s, dip_c, dip_s;
        t_out_item    pending[$];
        int           errors;

        function new();
            mode = MODE_BOTH;
            dec_c = Q1; dec_s = 0; dip_c = Q1; dip_s = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_MODE:    mode  = val[1:0];
                CFG_DEC_COS: dec_c = longint'($signed(val));
                CFG_DEC_SIN: dec_s = longint'($signed(val));
                CFG_DIP_COS: dip_c = longint'($signed(val));
                CFG_DIP_SIN: dip_s = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function longint unsigned abs64(longint a);
            return a < 0 ? longint'(0) - a : a;
        endfunction

        function longint clamp1(longint a);
            if (a > Q1) return Q1;
            if (a < -Q1) return -Q1;
            return a;
        endfunction

        // bit-serial integer square root, floor
        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // scale to a Q1.14 unit vector; zero length gives 0
        function bit to_unit(input longint a[3], output longint q[3]);
            longint unsigned s, n, m;
            longint r;
            s = 0;
            for (int i = 0; i < 3; i++) s += abs64(a[i]) * abs64(a[i]);
            if (s == 0) return 0;
            n = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                m = abs64(a[i]) * Q1;
                r = longint'((m + n / 2) / n);
                q[i] = clamp1(a[i] < 0 ? -r : r);
            end
            return 1;
        endfunction

        function longint round_q56(longint acc);
            longint unsigned m;
            longint r;
            m = (abs64(acc) + (64'd1 << 41)) >> 42;
            r = (m > 2 * Q1) ? 2 * Q1 : longint'(m);
            return clamp1(acc < 0 ? -r : r);
        endfunction

        // v' = c*v - s*(k x v) + k*(1-c)*(k.v), summed in Q.56
        function void spin(inout longint v[3], input longint k[3], input longint c,
                           input longint s);
            longint cr[3], res[3], dot, acc;
            cr[0] = k[1] * v[2] - k[2] * v[1];
            cr[1] = k[2] * v[0] - k[0] * v[2];
            cr[2] = k[0] * v[1] - k[1] * v[0];
            dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
            for (int i = 0; i < 3; i++) begin
                acc = c * v[i] * 64'sd268435456 - s * cr[i] * Q1 + k[i] * (Q1 - c) * dot;
                res[i] = round_q56(acc);
            end
            for (int i = 0; i < 3; i++) v[i] = res[i];
        endfunction

        // accepted item: work out its compensated field vector
        function void note_item(t_in_item it);
            longint m[3], g[3], v[3], k[3], ax[3], cr[3];
            bit ok;
            t_out_item r;
            m[0] = it.mag_x;  m[1] = it.mag_y;  m[2] = it.mag_z;
            g[0] = it.grav_x; g[1] = it.grav_y; g[2] = it.grav_z;
            ok = to_unit(m, v);
            ok = to_unit(g, k) && ok;
            if (ok && mode != MODE_DIP) spin(v, k, dec_c, dec_s);
            if (ok && mode != MODE_DEC) begin
                cr[0] = v[1] * k[2] - v[2] * k[1];
                cr[1] = v[2] * k[0] - v[0] * k[2];
                cr[2] = v[0] * k[1] - v[1] * k[0];
                ok = to_unit(cr, ax);
                if (ok) spin(v, ax, dip_c, dip_s);
            end
            r.out_x = ok ? v[0][15:0] : '0;
            r.out_y = ok ? v[1][15:0] : '0;
            r.out_z = ok ? v[2][15:0] : '0;
            r.degenerate = !ok;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_out_item r);
            t_out_item e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (r.out_x !== e.out_x) report("out_x", r.out_x, e.out_x);
            if (r.out_y !== e.out_y) report("out_y", r.out_y, e.out_y);
            if (r.out_z !== e.out_z) report("out_z", r.out_z, e.out_z);
            if (r.degenerate !== e.degenerate)
                report("degenerate", r.degenerate, e.degenerate);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_in_item    in_item;
    logic        done;
    t_out_item   result;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;

    rotation_scoreboard sb;
    bit  took_item;
    bit  no_idle;
    int  wdog;

    field_vector_dec_dip_rotate u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (in_item),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitor: note accepted items, check results, watchdog
    always @(posedge clk) begin
        took_item = rst_n && start && !busy;
        if (took_item) sb.note_item(in_item);
        if (rst_n && done) sb.check_result(result);
        if (took_item || done || cfg_we) begin
            wdog = 0;
        end else begin
            wdog++;
        end
        if (wdog >= WDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task send_item(t_in_item it);
        start   <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (!took_item) @(negedge clk);
        if (!no_idle && $urandom_range(99) < 27) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task write_all(logic [15:0] md, logic [15:0] dc, logic [15:0] ds,
                   logic [15:0] pc, logic [15:0] ps);
        write_reg(CFG_MODE, md);
        write_reg(CFG_DEC_COS, dc);
        write_reg(CFG_DEC_SIN, ds);
        write_reg(CFG_DIP_COS, pc);
        write_reg(CFG_DIP_SIN, ps);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic [15:0] a, logic [15:0] b,
                                           logic [15:0] c, logic [15:0] d,
                                           logic [15:0] e, logic [15:0] f);
        t_in_item it;
        it.mag_x = a; it.mag_y = b; it.mag_z = c;
        it.grav_x = d; it.grav_y = e; it.grav_z = f;
        return it;
    endfunction

    function automatic logic [15:0] small_val();
        return 16'($signed($urandom_range(128)) - 64);
    endfunction

    // random item: mostly full range, some small, parallel or zero vectors
    function automatic t_in_item rand_item();
        t_in_item it;
        int kind;
        kind = $urandom_range(99);
        it = t_in_item'({$urandom, $urandom, $urandom});
        if (kind < 15) begin
            it = make_item(small_val(), small_val(), small_val(),
                           small_val(), small_val(), small_val());
        end else if (kind < 23) begin
            // field parallel to gravity: no dip axis
            it.grav_x = it.mag_x; it.grav_y = it.mag_y; it.grav_z = it.mag_z;
            if (kind < 19) begin
                it.grav_x = -it.mag_x / 2; it.grav_y = -it.mag_y / 2;
                it.grav_z = -it.mag_z / 2;
            end
        end else if (kind < 26) begin
            it.mag_x = '0; it.mag_y = '0; it.mag_z = '0;
        end else if (kind < 29) begin
            it.grav_x = '0; it.grav_y = '0; it.grav_z = '0;
        end
        return it;
    endfunction

    function automatic logic [15:0] rand_angle();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'sd16384;
        if (k == 1) return -16'sd16384;
        if (k == 2) return 16'h8000;
        if (k == 3) return 16'h7fff;
        if (k == 4) return 16'd0;
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    initial begin
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        no_idle  = 1'b0;
        wdog     = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes and degenerate vectors at reset settings
        send_item(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        send_item(make_item(16'h7fff, 0, 0, 0, 0, 16'h7fff));
        send_item(make_item(0, 0, 0, 1, 2, 3));
        send_item(make_item(1, 2, 3, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0));
        send_item(make_item(100, 200, 300, 100, 200, 300));
        send_item(make_item(1, 0, 0, 0, 1, 0));
        send_item(make_item(16'hffff, 16'hffff, 16'hffff, 1, 1, 16'hffff));
        wait_drained();
        write_all(16'(MODE_BOTH), 16'd11585, 16'd11585, 16'd0, 16'sd16384);
        send_item(make_item(16'h8000, 16'h7fff, 0, 0, 0, 16'h8000));
        send_item(make_item(300, -400, 500, 10, 20, -30));
        send_item(make_item(5, 5, 5, -5, -5, -5));
        send_item(make_item(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h1234, 16'hedcb));
        wait_drained();
        write_all(16'hfffe, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_item(make_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        send_item(make_item(3, 4, 0, 0, 0, 1));
        send_item(make_item(3, 4, 0, 6, 8, 0));
        wait_drained();
        write_all(16'(MODE_DEC), -16'sd16384, 16'd0, 16'sd16384, 16'd0);
        send_item(make_item(3, 4, 0, 0, 0, 1));
        send_item(make_item(3, 4, 0, 6, 8, 0));
        wait_drained();
        write_all(16'h0003, 16'd0, -16'sd16384, 16'd0, -16'sd16384);
        send_item(make_item(3, 4, 0, 0, 0, 1));
        send_item(make_item(16'h8000, 16'h8000, 16'h8000, 1, 0, 0));

        // random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_all(16'(($urandom_range(16'hffff) & 32'hfffc) | (ph % 4)),
                      rand_angle(), rand_angle(), rand_angle(), rand_angle());
            no_idle = (ph == 2);
            for (int n = 0; n < 225; n++) send_item(rand_item());
        end
        no_idle = 1'b0;

        // drain, then let the pipeline settle
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
